// ===== hw/rtl/multimodal_position_id_generator_core_macros.svh =====
// Assertion macros shared by the position id generator RTL.
`ifndef MULTIMODAL_POSITION_ID_GENERATOR_CORE_MACROS_SVH
`define MULTIMODAL_POSITION_ID_GENERATOR_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MPID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define MPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpid_pkg.sv =====
// Shared types, codes and helper functions of the position id generator.
`timescale 1ns / 1ps

package mpid_pkg;

  // Input word kinds.
  typedef enum logic {
    OP_GRID  = 1'b0,
    OP_TOKEN = 1'b1
  } opcode_t;

  // Error codes reported on each result word.
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY_GRID = 3'd1,
    ERR_EXTRA_RUN  = 3'd2,
    ERR_RUN_LENGTH = 3'd3,
    ERR_MISS_RUN   = 3'd4,
    ERR_OVERFLOW   = 3'd5
  } err_code_t;

  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

  // One result word.
  typedef struct packed {
    logic [30:0]        pos_t;
    logic [30:0]        pos_h;
    logic [30:0]        pos_w;
    logic               is_image;
    err_code_t          error_code;
    logic signed [31:0] position_delta;
    logic               sequence_done;
  } res_t;

  // Saturate a 33-bit sum to 32 bits.
  function automatic logic [31:0] sat32(input logic [32:0] s);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Clamp a 33-bit sum to the 31-bit position range.
  function automatic logic [30:0] pos31(input logic [32:0] s);
    return (|s[32:31]) ? POS_MAX : s[30:0];
  endfunction

  // Pick the lowest raised error.
  function automatic err_code_t code_of(input logic [5:1] f);
    err_code_t c;
    if (f[1]) begin
      c = ERR_EMPTY_GRID;
    end else if (f[2]) begin
      c = ERR_EXTRA_RUN;
    end else if (f[3]) begin
      c = ERR_RUN_LENGTH;
    end else if (f[4]) begin
      c = ERR_MISS_RUN;
    end else if (f[5]) begin
      c = ERR_OVERFLOW;
    end else begin
      c = ERR_NONE;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mpid_grid_mem.sv =====
// Grid table memory: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps

module mpid_grid_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 30,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Store a loaded grid.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Prefetch the addressed entry; forward a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/mpid_token_unit.sv =====
// Position state and the single-pass step for one grid load or token.
`timescale 1ns / 1ps

module mpid_token_unit #(
  parameter int MAX_IMAGES    = 16,
  parameter int GRID_DIM_BITS = 10,
  localparam int D     = GRID_DIM_BITS,
  localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1,
  localparam int CNT_W = $clog2(MAX_IMAGES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic               op,
  input  logic [23:0]        token_id,
  input  logic               last,
  input  logic [23:0]        pad_id,
  input  logic [3*D-1:0]     rd_grid,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [IDX_W-1:0]   rd_addr,
  output mpid_pkg::res_t     res
);

  import mpid_pkg::*;

  // Position state.
  logic [31:0]      lp;
  logic [31:0]      base;
  logic [D-1:0]     tc, hc, wc;
  logic [D-1:0]     cg_t, cg_h, cg_w;
  logic             in_run;
  logic [31:0]      seen;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] loaded;

  // Step intermediates.
  logic             token_step;
  logic             pad, start, img, closing, empty, exhausted;
  logic [D-1:0]     rd_t, rd_h, rd_w, g_t, g_h, g_w;
  logic [D-1:0]     t0, h0, w0, t1, h1, w1;
  logic [D:0]       w_inc, h_inc;
  logic [31:0]      b, seen_n, lp_a, lp_txt, lp_fin;
  logic [32:0]      s_t, s_h, s_w, sum_c, sum_c1, sum_g, d;
  logic [CNT_W-1:0] cursor_a, cursor_next;
  logic [5:1]       flags;
  logic [31:0]      delta;

  function automatic logic [D-1:0] max3(input logic [D-1:0] a, input logic [D-1:0] x,
                                        input logic [D-1:0] y);
    logic [D-1:0] m;
    m = a;
    if (x > m) m = x;
    if (y > m) m = y;
    return m;
  endfunction

  assign {rd_t, rd_h, rd_w} = rd_grid;
  assign token_step = step_en && (op == OP_TOKEN);

  // Place one token.
  always_comb begin
    pad     = (token_id == pad_id);
    seen_n  = (&seen) ? seen : seen + 32'd1;
    closing = in_run && !pad;
    start   = pad && !in_run && (cursor < loaded);
    img     = pad && (in_run || start);
    empty   = (rd_t == '0) || (rd_h == '0) || (rd_w == '0);

    g_t = start ? rd_t : cg_t;
    g_h = start ? rd_h : cg_h;
    g_w = start ? rd_w : cg_w;
    b   = start ? lp : base;
    t0  = start ? (empty ? rd_t : '0) : tc;
    h0  = start ? '0 : hc;
    w0  = start ? '0 : wc;

    s_t = 33'(b) + 33'(t0);
    s_h = 33'(b) + 33'(h0);
    s_w = 33'(b) + 33'(w0);

    // Advance the t-major, w-fastest walk unless the grid is used up.
    exhausted = (t0 >= g_t);
    w_inc = {1'b0, w0} + 1'b1;
    h_inc = {1'b0, h0} + 1'b1;
    t1 = t0;
    h1 = h0;
    w1 = w0;
    if (!exhausted) begin
      if (w_inc >= {1'b0, g_w}) begin
        w1 = '0;
        if (h_inc >= {1'b0, g_h}) begin
          h1 = '0;
          t1 = t0 + 1'b1;
        end else begin
          h1 = h_inc[D-1:0];
        end
      end else begin
        w1 = w_inc[D-1:0];
      end
    end

    // Close a run on a text token; the +1 variant folds in the text advance.
    sum_c  = 33'(base) + 33'(max3(cg_t, cg_h, cg_w));
    sum_c1 = 33'(base) + 33'(max3(cg_t, cg_h, cg_w)) + 33'd1;
    lp_a   = closing ? sat32(sum_c) : lp;
    lp_txt = closing ? sat32(sum_c1) : sat32(33'(lp) + 33'd1);
    sum_g  = 33'(b) + 33'(max3(g_t, g_h, g_w));

    flags = '0;
    if (closing && (tc < cg_t)) flags[3] = 1'b1;
    if (start && empty) flags[1] = 1'b1;
    if (img) begin
      if (exhausted) flags[3] = 1'b1;
      if ((|s_t[32:31]) || (|s_h[32:31]) || (|s_w[32:31])) flags[5] = 1'b1;
    end else begin
      if (pad) flags[2] = 1'b1;
      if (lp_a[31]) flags[5] = 1'b1;
    end

    // Close out the sequence on the last token.
    cursor_a = start ? cursor + 1'b1 : cursor;
    lp_fin   = img ? sat32(sum_g) : lp_txt;
    d        = 33'(lp_fin) - 33'(seen_n);
    delta    = '0;
    if (last) begin
      if (img && (t1 < g_t)) flags[3] = 1'b1;
      if (cursor_a < loaded) flags[4] = 1'b1;
      if (d[32] != d[31]) begin
        flags[5] = 1'b1;
        delta = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        delta = d[31:0];
      end
    end

    res.pos_t          = img ? pos31(s_t) : pos31(33'(lp_a));
    res.pos_h          = img ? pos31(s_h) : pos31(33'(lp_a));
    res.pos_w          = img ? pos31(s_w) : pos31(33'(lp_a));
    res.is_image       = img;
    res.error_code     = code_of(flags);
    res.position_delta = delta;
    res.sequence_done  = last;
  end

  // Grid table write and prefetch address.
  always_comb begin
    wr_en       = step_en && (op == OP_GRID) && (loaded < CNT_W'(MAX_IMAGES));
    wr_addr     = loaded[IDX_W-1:0];
    cursor_next = cursor;
    if (token_step) begin
      cursor_next = last ? '0 : cursor_a;
    end
    rd_addr = cursor_next[IDX_W-1:0];
  end

  // Update control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lp     <= '0;
      base   <= '0;
      tc     <= '0;
      hc     <= '0;
      wc     <= '0;
      in_run <= 1'b0;
      seen   <= '0;
      cursor <= '0;
      loaded <= '0;
    end else if (wr_en) begin
      loaded <= loaded + 1'b1;
    end else if (token_step) begin
      if (last) begin
        lp     <= '0;
        base   <= '0;
        tc     <= '0;
        hc     <= '0;
        wc     <= '0;
        in_run <= 1'b0;
        seen   <= '0;
        cursor <= '0;
        loaded <= '0;
      end else begin
        seen   <= seen_n;
        cursor <= cursor_a;
        in_run <= img;
        if (img) begin
          base <= b;
          tc   <= t1;
          hc   <= h1;
          wc   <= w1;
        end else begin
          lp <= lp_txt;
        end
      end
    end
  end

  // Hold the grid of the current run.
  always_ff @(posedge clk) begin
    if (token_step && start) begin
      cg_t <= rd_t;
      cg_h <= rd_h;
      cg_w <= rd_w;
    end
  end

endmodule

// ===== hw/rtl/multimodal_position_id_generator_core.sv =====
// Top level of the multimodal 3-D position id generator.
`timescale 1ns / 1ps
`include "multimodal_position_id_generator_core_macros.svh"

// Takes grid-load words and token words on one valid/stall channel and returns
// one result word (three axis positions, image flag, error code, and on the
// last token the position delta) for each token; a grid load returns nothing.
// One word is taken every clock cycle while in_stall is low. A token passes
// from the input register through the single-pass position step into the
// result register. The grid table is a memory whose entry for the next run
// is prefetched into a read register, so a run can start on any token. While
// a finished result waits to be taken, the input register takes one more word
// and grid loads keep passing through. A token held behind the waiting result
// stalls the input until the result is taken. No clearing pass is needed after
// reset.
module multimodal_position_id_generator_core #(
  parameter int MAX_IMAGES    = 16,
  parameter int GRID_DIM_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [23:0]              cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic [23:0]              token_id,
  input  logic [GRID_DIM_BITS-1:0] grid_t,
  input  logic [GRID_DIM_BITS-1:0] grid_h,
  input  logic [GRID_DIM_BITS-1:0] grid_w,
  input  logic                     last_token,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [30:0]              pos_t,
  output logic [30:0]              pos_h,
  output logic [30:0]              pos_w,
  output logic                     is_image,
  output logic [2:0]               error_code,
  output logic signed [31:0]       position_delta,
  output logic                     sequence_done
);

  import mpid_pkg::*;

  localparam int D     = GRID_DIM_BITS;
  localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

  logic             image_pad_id;
  logic [23:0]      pad_id;
  logic             s1_valid;
  logic             s1_op;
  logic [23:0]      s1_token_id;
  logic [3*D-1:0]   s1_grid;
  logic             s1_last;
  logic             out_free;
  logic             s1_fire;
  logic             tok_fire;
  logic             in_take;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [3*D-1:0]   rd_grid;
  res_t             res;
  res_t             res_q;

  assign image_pad_id = 1'b1;

  // Hold the image pad token id.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_id <= '0;
    end else if (cfg_wr_en && image_pad_id) begin
      pad_id <= cfg_wr_data;
    end
  end

  // Handshake: grid loads never wait on the result side.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && ((s1_op == OP_GRID) || out_free);
  assign tok_fire = s1_fire && (s1_op == OP_TOKEN);
  assign in_stall = s1_valid && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op       <= opcode;
      s1_token_id <= token_id;
      s1_grid     <= {grid_t, grid_h, grid_w};
      s1_last     <= last_token;
    end
  end

  mpid_grid_mem #(
    .DEPTH (MAX_IMAGES),
    .WIDTH (3 * D)
  ) u_grid_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_grid),
    .rd_addr (rd_addr),
    .rd_data (rd_grid)
  );

  mpid_token_unit #(
    .MAX_IMAGES    (MAX_IMAGES),
    .GRID_DIM_BITS (GRID_DIM_BITS)
  ) u_token_unit (
    .clk      (clk),
    .rst      (rst),
    .step_en  (s1_fire),
    .op       (s1_op),
    .token_id (s1_token_id),
    .last     (s1_last),
    .pad_id   (pad_id),
    .rd_grid  (rd_grid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_fire) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_fire) begin
      res_q <= res;
    end
  end

  assign pos_t          = res_q.pos_t;
  assign pos_h          = res_q.pos_h;
  assign pos_w          = res_q.pos_w;
  assign is_image       = res_q.is_image;
  assign error_code     = res_q.error_code;
  assign position_delta = res_q.position_delta;
  assign sequence_done  = res_q.sequence_done;

  // Assertions.
  `MPID_ASSERT_NEXT(a_grid_no_word, clk, rst, s1_fire && (s1_op == OP_GRID) && out_free, !out_valid, "grid load produced a result word")
  `MPID_ASSERT_NEXT(a_take_fills, clk, rst, in_take, s1_valid, "accepted word not held in input register")
  `MPID_ASSERT_SAME(a_text_axes, clk, rst, out_valid && !is_image, (pos_t == pos_h) && (pos_h == pos_w), "text token axes differ")
  `MPID_ASSERT_SAME(a_delta_last, clk, rst, out_valid && !sequence_done, position_delta == 32'sd0, "delta reported before last token")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multimodal 3-D position id generator core.
`timescale 1ns / 1ps

module tb_top;
  import mpid_pkg::*;

  localparam int GRID_SLOTS  = 16;
  localparam int DRAIN_WAIT  = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 400;

  // Tracks the expected position words and compares the block's results.
  class position_scoreboard;
    localparam longint INT32_TOP    = 64'sd2147483647;
    localparam longint INT32_BOTTOM = -64'sd2147483648;

    bit [23:0]   pad_id;
    bit [9:0]    slot_t [GRID_SLOTS];
    bit [9:0]    slot_h [GRID_SLOTS];
    bit [9:0]    slot_w [GRID_SLOTS];
    int unsigned slots_used;
    int unsigned next_slot;
    bit [31:0]   next_pos;
    bit [31:0]   run_base;
    bit [31:0]   tokens_seen;
    int unsigned t_idx;
    int unsigned h_idx;
    int unsigned w_idx;
    bit          in_run;
    bit [5:1]    raised;
    res_t        expected_positions[$];
    int          mismatches;
    int          checked;

    function void clear_sequence();
      foreach (slot_t[i]) begin
        slot_t[i] = '0;
        slot_h[i] = '0;
        slot_w[i] = '0;
      end
      slots_used  = 0;
      next_slot   = 0;
      next_pos    = '0;
      run_base    = '0;
      tokens_seen = '0;
      t_idx       = 0;
      h_idx       = 0;
      w_idx       = 0;
      in_run      = 1'b0;
    endfunction

    function new();
      pad_id     = '0;
      mismatches = 0;
      checked    = 0;
      clear_sequence();
    endfunction

    function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Clamp a position to the 31-bit range and flag overflow.
    function bit [31:0] place(bit [31:0] b, bit [31:0] off);
      bit [32:0] s;
      s = {1'b0, b} + {1'b0, off};
      if (s > {2'b00, POS_MAX}) begin
        raised[ERR_OVERFLOW] = 1'b1;
        return {1'b0, POS_MAX};
      end
      return s[31:0];
    endfunction

    // Close the current run: check its length and jump past the widest axis.
    function void close_image_run();
      int unsigned g;
      bit [31:0]   widest;
      g = next_slot - 1;
      widest = 32'(slot_t[g]);
      if (t_idx < slot_t[g]) raised[ERR_RUN_LENGTH] = 1'b1;
      if (slot_h[g] > widest) widest = 32'(slot_h[g]);
      if (slot_w[g] > widest) widest = 32'(slot_w[g]);
      next_pos = sat_add(run_base, widest);
      in_run = 1'b0;
    endfunction

    // Note one accepted input word and, for a token, queue the position word it produces.
    function void take_word(opcode_t op, bit [23:0] tok, bit [9:0] gt, bit [9:0] gh,
                            bit [9:0] gw, bit last);
      bit          pad;
      bit          img;
      bit [31:0]   pt;
      bit [31:0]   ph;
      bit [31:0]   pw;
      longint      delta;
      int unsigned g;
      err_code_t   code;
      res_t        r;
      if (op == OP_GRID) begin
        if (slots_used < GRID_SLOTS) begin
          slot_t[slots_used] = gt;
          slot_h[slots_used] = gh;
          slot_w[slots_used] = gw;
          slots_used++;
        end
        return;
      end
      raised = '0;
      img    = 1'b0;
      delta  = 0;
      pad    = (tok == pad_id);
      tokens_seen = sat_add(tokens_seen, 32'd1);

      if (in_run && !pad) close_image_run();

      // Open a run on the next unused grid.
      if (pad && !in_run && next_slot < slots_used) begin
        g = next_slot;
        next_slot++;
        run_base = next_pos;
        t_idx    = 0;
        h_idx    = 0;
        w_idx    = 0;
        in_run   = 1'b1;
        if (slot_t[g] == 0 || slot_h[g] == 0 || slot_w[g] == 0) begin
          raised[ERR_EMPTY_GRID] = 1'b1;
          t_idx = 32'(slot_t[g]);
        end
      end

      if (pad && in_run) begin
        g   = next_slot - 1;
        img = 1'b1;
        pt  = place(run_base, t_idx);
        ph  = place(run_base, h_idx);
        pw  = place(run_base, w_idx);
        // Advance w fastest, then h, then t.
        if (t_idx >= slot_t[g]) begin
          raised[ERR_RUN_LENGTH] = 1'b1;
        end else begin
          w_idx++;
          if (w_idx >= slot_w[g]) begin
            w_idx = 0;
            h_idx++;
            if (h_idx >= slot_h[g]) begin
              h_idx = 0;
              t_idx++;
            end
          end
        end
      end else begin
        if (pad) raised[ERR_EXTRA_RUN] = 1'b1;
        pt = place(next_pos, 32'd0);
        ph = pt;
        pw = pt;
        next_pos = sat_add(next_pos, 32'd1);
      end

      if (last) begin
        if (in_run) close_image_run();
        if (next_slot < slots_used) raised[ERR_MISS_RUN] = 1'b1;
        delta = $signed({32'd0, next_pos}) - $signed({32'd0, tokens_seen});
        if (delta > INT32_TOP) begin
          raised[ERR_OVERFLOW] = 1'b1;
          delta = INT32_TOP;
        end else if (delta < INT32_BOTTOM) begin
          raised[ERR_OVERFLOW] = 1'b1;
          delta = INT32_BOTTOM;
        end
        clear_sequence();
      end

      // Lowest raised code wins.
      code = ERR_NONE;
      for (int k = ERR_OVERFLOW; k >= ERR_EMPTY_GRID; k--) begin
        if (raised[k]) code = err_code_t'(k);
      end

      r.pos_t          = pt[30:0];
      r.pos_h          = ph[30:0];
      r.pos_w          = pw[30:0];
      r.is_image       = img;
      r.error_code     = code;
      r.position_delta = delta[31:0];
      r.sequence_done  = last;
      expected_positions = {expected_positions, r};
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] exp);
      if (got !== exp) report($sformatf("%s got 'h%0h expected 'h%0h", name, got, exp));
    endtask

    // Compare one accepted result word with the oldest expectation.
    task check_position(res_t got);
      res_t exp;
      if (expected_positions.size() == 0) begin
        report($sformatf("result with nothing expected (pos_t 'h%0h)", got.pos_t));
        return;
      end
      exp = expected_positions.pop_front();
      checked++;
      check_field("pos_t", got.pos_t, exp.pos_t);
      check_field("pos_h", got.pos_h, exp.pos_h);
      check_field("pos_w", got.pos_w, exp.pos_w);
      check_field("is_image", got.is_image, exp.is_image);
      check_field("error_code", got.error_code, exp.error_code);
      check_field("position_delta", got.position_delta, exp.position_delta);
      check_field("sequence_done", got.sequence_done, exp.sequence_done);
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [23:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [23:0]        token_id;
  logic [9:0]         grid_t;
  logic [9:0]         grid_h;
  logic [9:0]         grid_w;
  logic               last_token;
  logic               out_valid;
  logic               out_stall;
  logic [30:0]        pos_t;
  logic [30:0]        pos_h;
  logic [30:0]        pos_w;
  logic               is_image;
  logic [2:0]         error_code;
  logic signed [31:0] position_delta;
  logic               sequence_done;

  position_scoreboard sb = new();
  bit no_idle;
  bit backpressure_req;
  int words_sent;
  int grids_sent;
  int pad_settings;

  multimodal_position_id_generator_core u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .token_id       (token_id),
    .grid_t         (grid_t),
    .grid_h         (grid_h),
    .grid_w         (grid_w),
    .last_token     (last_token),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pos_t          (pos_t),
    .pos_h          (pos_h),
    .pos_w          (pos_w),
    .is_image       (is_image),
    .error_code     (error_code),
    .position_delta (position_delta),
    .sequence_done  (sequence_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the whole run.
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one word, idling at random first, and hold it until accepted.
  task automatic send_word(opcode_t op, bit [23:0] tok, bit [9:0] gt, bit [9:0] gh,
                           bit [9:0] gw, bit last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    token_id   <= tok;
    grid_t     <= gt;
    grid_h     <= gh;
    grid_w     <= gw;
    last_token <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_word(op, tok, gt, gh, gw, last);
    words_sent++;
    if (op == OP_GRID) grids_sent++;
  endtask

  task automatic send_grid(bit [9:0] gt, bit [9:0] gh, bit [9:0] gw);
    send_word(OP_GRID, 24'($urandom), gt, gh, gw, 1'($urandom_range(1)));
  endtask

  // Send an image-pad token or a text token with a random non-pad id.
  task automatic send_token(bit pad, bit last);
    bit [23:0] tok;
    tok = sb.pad_id;
    if (!pad) begin
      do tok = 24'($urandom); while (tok == sb.pad_id);
    end
    send_word(OP_TOKEN, tok, 10'($urandom), 10'($urandom), 10'($urandom), last);
  endtask

  // Drop valid and wait for every expected word plus the pipeline latency.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_pad_id(bit [23:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.pad_id = v;
    pad_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One sequence: load grids, then text and image runs, ending on a last token.
  task automatic run_sequence();
    int        n;
    int        r;
    int        len;
    int        ntext;
    bit [9:0]  gt;
    bit [9:0]  gh;
    bit [9:0]  gw;
    bit [9:0]  dt[$];
    bit [9:0]  dh[$];
    bit [9:0]  dw[$];
    n = ($urandom_range(99) < 6) ? $urandom_range(15, 18) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      gt = 10'($urandom_range(1, 3));
      gh = 10'($urandom_range(1, 3));
      gw = 10'($urandom_range(1, 3));
      if (r < 10) begin
        case ($urandom_range(2))
          0: gt = '0;
          1: gh = '0;
          default: gw = '0;
        endcase
      end else if (r < 18) begin
        gt = 10'($urandom);
        gh = 10'($urandom);
        gw = 10'($urandom);
      end else if (r < 20) begin
        gt = 10'd1;
        gh = 10'd1;
        gw = 10'($urandom_range(40, 200));
      end
      send_grid(gt, gh, gw);
      if (dt.size() < GRID_SLOTS) begin
        dt = {dt, gt};
        dh = {dh, gh};
        dw = {dw, gw};
      end
    end

    foreach (dt[i]) begin
      ntext = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (ntext) send_token(1'b0, 1'b0);
      if ($urandom_range(99) < 4) continue;
      len = dt[i] * dh[i] * dw[i];
      r = $urandom_range(99);
      if (len == 0) begin
        len = $urandom_range(1, 3);
      end else if (len > 250) begin
        len = $urandom_range(1, 6);
      end else if (r < 6) begin
        len += $urandom_range(1, 2);
      end else if (r < 12 && len > 1) begin
        len -= 1;
      end
      repeat (len) send_token(1'b1, 1'b0);
      if ($urandom_range(99) < 4) begin
        send_grid(10'($urandom_range(0, 3)), 10'($urandom_range(1, 3)), 10'($urandom));
      end
    end

    // Pad run after the planned runs; it finds a grid only if one was left unused.
    if ($urandom_range(99) < 5) begin
      send_token(1'b0, 1'b0);
      repeat ($urandom_range(1, 2)) send_token(1'b1, 1'b0);
    end

    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(0, 2)) send_token(1'b0, 1'b0);
      send_token(1'b0, 1'b1);
    end else begin
      send_token(1'b1, 1'b1);
    end
  endtask

  // Result side: random stall, long hold-off on request, check on accept.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (backpressure_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        backpressure_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 17);
      end
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        res_t got;
        got.pos_t          = pos_t;
        got.pos_h          = pos_h;
        got.pos_w          = pos_w;
        got.is_image       = is_image;
        got.error_code     = err_code_t'(error_code);
        got.position_delta = position_delta;
        got.sequence_done  = sequence_done;
        sb.check_position(got);
      end
    end
  end

  // Stimulus: reset, directed cases, then four random phases.
  initial begin
    int        goal;
    bit [23:0] pad_choice;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    opcode           = OP_GRID;
    token_id         = '0;
    grid_t           = '0;
    grid_h           = '0;
    grid_w           = '0;
    last_token       = 1'b0;
    out_stall        = 1'b0;
    no_idle          = 1'b0;
    backpressure_req = 1'b0;
    words_sent       = 0;
    grids_sent       = 0;
    pad_settings     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_pad_id(24'h000000);
    // exact run, empty grid, run too long, early close, extra run
    send_grid(10'd1, 10'd2, 10'd2);
    send_grid(10'd0, 10'd3, 10'd1023);
    send_grid(10'd1023, 10'd1023, 10'd1023);
    send_word(OP_TOKEN, 24'hFFFFFF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b0);
    repeat (4) send_token(1'b1, 1'b0);
    send_token(1'b0, 1'b0);
    repeat (2) send_token(1'b1, 1'b0);
    send_token(1'b0, 1'b0);
    repeat (2) send_token(1'b1, 1'b0);
    send_token(1'b0, 1'b0);
    send_token(1'b1, 1'b0);
    send_token(1'b0, 1'b1);
    // overlong run, then last token with a grid never used
    send_grid(10'd1, 10'd1, 10'd1);
    send_grid(10'd2, 10'd1, 10'd1);
    repeat (2) send_token(1'b1, 1'b0);
    send_token(1'b0, 1'b1);
    // last token inside an image run
    send_grid(10'd1, 10'd1, 10'd2);
    send_token(1'b1, 1'b0);
    send_token(1'b1, 1'b1);
    drain();

    for (int ph = 1; ph <= 4; ph++) begin
      pad_choice = (ph == 1) ? 24'hFFFFFF : (ph == 4) ? 24'h000000 : 24'($urandom);
      set_pad_id(pad_choice);
      no_idle = (ph == 2);
      if (ph == 1 || ph == 3) backpressure_req = 1'b1;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        if ($urandom_range(99) < 8) begin
          send_word(opcode_t'($urandom_range(1)), 24'($urandom), 10'($urandom),
                    10'($urandom), 10'($urandom), 1'($urandom_range(1)));
        end else begin
          run_sequence();
        end
        if ($urandom_range(19) == 0) drain();
      end
      drain();
    end

    $display("Run: %0d words (%0d grid loads), %0d position words checked, %0d pad-id settings.",
             words_sent, grids_sent, sb.checked, pad_settings);
    $display("Covered empty, short, long, extra and missing runs under stall and hold-off.");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
